// ===== rtl/ffra_pkg.sv =====
// ffra_pkg: shared constants, types and codes for the first-fit run allocator.
// Used by ffra_word_eval and first_fit_run_allocator; depends on nothing.
`default_nettype none

package ffra_pkg;

	localparam int SLOT_COUNT_DEF = 2048;

	// occupancy map is held as words of WORD_W slots, one word per RAM row
	localparam int WORD_W = 32;
	localparam int OFS_W = 5;          // $clog2(WORD_W)

	localparam int START_W = 11;
	localparam int LEN_W = 12;
	localparam int BASE_W = 11;
	localparam int CNT_W = LEN_W + 1;  // free run count, stays below len + WORD_W

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_RANGE,
		ST_MARK,
		ST_DONE
	} state_t;

	// per-word scan result
	typedef struct packed {
		logic carry_hit;             // run coming in from lower words completes here
		logic inner_hit;             // a fitting run lies wholly inside this word
		logic [OFS_W-1:0] inner_pos; // lowest base of such a run
		logic all_free;
		logic [OFS_W:0] lead;        // free slots at the top of the word
	} eval_t;

endpackage

`default_nettype wire

// ===== rtl/ffra_ram.sv =====
// ffra_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ffra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ffra_word_eval.sv =====
// ffra_word_eval: first-fit search over one map word, given the free run carried in.
// Depends on ffra_pkg.
`default_nettype none

module ffra_word_eval (
	input  wire logic [ffra_pkg::WORD_W-1:0] used,
	input  wire logic [ffra_pkg::CNT_W-1:0]  cnt,
	input  wire logic [ffra_pkg::LEN_W-1:0]  len,
	output ffra_pkg::eval_t                  ev
);

	localparam int W = ffra_pkg::WORD_W;
	localparam int OW = ffra_pkg::OFS_W;

	logic [OW:0]      trail;
	logic [OW:0]      lead;
	logic [W-1:0]     lmask;
	logic [W-1:0]     win;
	logic [2*W-1:0]   ext;
	logic [OW-1:0]    pos;
	logic             fits;

	always_comb begin
		trail = (OW + 1)'(W);
		for (int i = W - 1; i >= 0; i--) begin
			if (used[i]) begin
				trail = (OW + 1)'(i);
			end
		end
		lead = (OW + 1)'(W);
		for (int i = 0; i < W; i++) begin
			if (used[i]) begin
				lead = (OW + 1)'(W - 1 - i);
			end
		end
		for (int i = 0; i < W; i++) begin
			lmask[i] = ffra_pkg::LEN_W'(i) < len;
		end
		// ones above the word block windows that would run into the next word
		ext = {{W{1'b1}}, used};
		for (int s = 0; s < W; s++) begin
			win[s] = (ext[s +: W] & lmask) == '0;
		end
		fits = (len != '0) && (len <= ffra_pkg::LEN_W'(W));
		pos = '0;
		for (int s = W - 1; s >= 0; s--) begin
			if (win[s]) begin
				pos = OW'(s);
			end
		end
		ev.carry_hit = ({1'b0, cnt} + (ffra_pkg::CNT_W + 1)'(trail)) >=
			(ffra_pkg::CNT_W + 1)'(len);
		ev.inner_hit = fits && (win != '0);
		ev.inner_pos = pos;
		ev.all_free = used == '0;
		ev.lead = lead;
	end

endmodule

`default_nettype wire

// ===== rtl/first_fit_run_allocator.sv =====
// first_fit_run_allocator: slot occupancy map with first-fit run allocation and range free.
// Depends on ffra_pkg, ffra_ram, ffra_word_eval.
//
// Usage: drive cmd, start_index and run_length and raise start; the command
// transfers at the rising edge where start is high and busy is low. busy then
// stays high until the result has gone out. The result (ok, base_index) is
// valid for exactly one cycle while done is high; the receiver cannot stall.
// The map sits in a RAM of 32-slot words. Allocate reads one word per cycle
// through the word evaluator, carrying the free run across words, until the
// first fitting run; then the run is marked by read-modify-write, one word per
// cycle. Free goes straight to that marking pass with the clamped range.
// At SLOT_COUNT = 2048 the map holds 64 words. Allocate of zero length or of more
// than SLOT_COUNT slots, and free of an empty range, go straight to the result.
// Reset: a clearing pass writes every word free, one word per cycle, with busy
// high; the first command follows it.
`default_nettype none

module first_fit_run_allocator #(
	parameter int SLOT_COUNT = ffra_pkg::SLOT_COUNT_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         cmd,
	input  wire logic [ffra_pkg::START_W-1:0] start_index,
	input  wire logic [ffra_pkg::LEN_W-1:0]   run_length,
	output logic                              busy,
	output logic                              done,
	output logic                              ok,
	output logic [ffra_pkg::BASE_W-1:0]       base_index
);

	localparam int W = ffra_pkg::WORD_W;
	localparam int OW = ffra_pkg::OFS_W;
	localparam int NW = (SLOT_COUNT + W - 1) / W;
	localparam int AW = (NW > 1) ? $clog2(NW) : 1;
	localparam int WC_W = AW + 1;
	localparam int PW = $clog2(NW * W + 2 ** ffra_pkg::LEN_W);
	localparam int LAST_VALID = SLOT_COUNT - (NW - 1) * W;
	// slots past the pool's end in the last word count as used
	localparam logic [W-1:0] LAST_PAD = ~({W{1'b1}} >> (W - LAST_VALID));

	ffra_pkg::state_t state_q, state_d;

	logic                        cmd_q;
	logic [ffra_pkg::LEN_W-1:0]  len_q;
	logic [ffra_pkg::LEN_W-1:0]  lenm1_q;
	logic [PW-1:0]               lo_q;
	logic [WC_W-1:0]             hw_q;
	logic [OW-1:0]               hoff_q;
	logic [WC_W-1:0]             rd_q;
	logic                        ev_v_q;
	logic [AW-1:0]               ev_q;
	logic [ffra_pkg::CNT_W-1:0]  cnt_q;
	logic [PW-1:0]               run_base_q;
	logic                        ok_q;
	logic [ffra_pkg::BASE_W-1:0] base_q;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [W-1:0]                ram_wdata;
	logic [W-1:0]                ram_rdata;
	logic [W-1:0]                used_word;
	ffra_pkg::eval_t             ev;

	logic                        free_skip;
	logic                        alloc_skip;
	logic                        last_word;
	logic [PW-1:0]               word_base;
	logic [PW-1:0]               inner_base;
	logic [PW-1:0]               hm1;
	logic [W-1:0]                m_lo;
	logic [W-1:0]                m_hi;
	logic [W-1:0]                mask;

	ffra_ram #(
		.WIDTH(W),
		.DEPTH(NW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign last_word = ev_q == AW'(NW - 1);
	assign used_word = ram_rdata | (last_word ? LAST_PAD : '0);

	ffra_word_eval u_eval (
		.used(used_word),
		.cnt (cnt_q),
		.len (len_q),
		.ev  (ev)
	);

	assign free_skip = (PW'(start_index) >= PW'(SLOT_COUNT)) || (run_length == '0);
	assign alloc_skip = (run_length == '0) || (PW'(run_length) > PW'(SLOT_COUNT));
	assign word_base = PW'({ev_q, {OW{1'b0}}});
	assign inner_base = PW'({ev_q, ev.inner_pos});
	assign hm1 = ((lo_q + PW'(lenm1_q)) >= PW'(SLOT_COUNT)) ? PW'(SLOT_COUNT - 1) :
		lo_q + PW'(lenm1_q);

	// bits of the marked range that fall in the current word
	assign m_lo = (WC_W'(ev_q) == WC_W'(lo_q >> OW)) ? ({W{1'b1}} << lo_q[OW-1:0]) :
		{W{1'b1}};
	assign m_hi = (WC_W'(ev_q) == hw_q) ? ({W{1'b1}} >> (OW'(W - 1) - hoff_q)) :
		{W{1'b1}};
	assign mask = m_lo & m_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffra_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = ev_q;
		ram_wdata = '0;
		busy = state_q != ffra_pkg::ST_IDLE;
		done = state_q == ffra_pkg::ST_DONE;
		case (state_q)
			ffra_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = rd_q[AW-1:0];
				if (rd_q == WC_W'(NW - 1)) begin
					state_d = ffra_pkg::ST_IDLE;
				end
			end
			ffra_pkg::ST_IDLE: begin
				if (start) begin
					if (cmd == ffra_pkg::CMD_FREE) begin
						state_d = free_skip ? ffra_pkg::ST_DONE : ffra_pkg::ST_RANGE;
					end else begin
						state_d = alloc_skip ? ffra_pkg::ST_DONE : ffra_pkg::ST_SCAN;
					end
				end
			end
			ffra_pkg::ST_SCAN: begin
				if (ev_v_q) begin
					if (ev.carry_hit || ev.inner_hit) begin
						state_d = ffra_pkg::ST_RANGE;
					end else if (last_word) begin
						state_d = ffra_pkg::ST_DONE;
					end
				end
			end
			ffra_pkg::ST_RANGE: begin
				state_d = ffra_pkg::ST_MARK;
			end
			ffra_pkg::ST_MARK: begin
				if (ev_v_q) begin
					ram_we = 1'b1;
					ram_wdata = (cmd_q == ffra_pkg::CMD_ALLOC) ? (ram_rdata | mask) :
						(ram_rdata & ~mask);
					if (WC_W'(ev_q) == hw_q) begin
						state_d = ffra_pkg::ST_DONE;
					end
				end
			end
			ffra_pkg::ST_DONE: begin
				state_d = ffra_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffra_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			ev_v_q <= 1'b0;
		end else begin
			case (state_q)
				ffra_pkg::ST_CLEAR: begin
					rd_q <= rd_q + 1'b1;
				end
				ffra_pkg::ST_IDLE: begin
					rd_q <= '0;
					ev_v_q <= 1'b0;
				end
				ffra_pkg::ST_SCAN, ffra_pkg::ST_MARK: begin
					// read pointer runs one word ahead of the data being evaluated
					rd_q <= rd_q + 1'b1;
					ev_v_q <= (state_q == ffra_pkg::ST_SCAN) ? (rd_q < WC_W'(NW)) :
						(rd_q <= hw_q);
				end
				ffra_pkg::ST_RANGE: begin
					rd_q <= WC_W'(lo_q >> OW);
					ev_v_q <= 1'b0;
				end
				default: begin
					ev_v_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ffra_pkg::ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					len_q <= run_length;
					lenm1_q <= run_length - 1'b1;
					lo_q <= PW'(start_index);
					cnt_q <= '0;
					run_base_q <= '0;
					ok_q <= cmd == ffra_pkg::CMD_FREE;
					base_q <= '0;
				end
			end
			ffra_pkg::ST_SCAN: begin
				ev_q <= rd_q[AW-1:0];
				if (ev_v_q) begin
					if (ev.carry_hit) begin
						lo_q <= run_base_q;
						ok_q <= 1'b1;
						base_q <= run_base_q[ffra_pkg::BASE_W-1:0];
					end else if (ev.inner_hit) begin
						lo_q <= inner_base;
						ok_q <= 1'b1;
						base_q <= inner_base[ffra_pkg::BASE_W-1:0];
					end else if (ev.all_free) begin
						cnt_q <= cnt_q + ffra_pkg::CNT_W'(W);
					end else begin
						// restart the run after the highest used slot of this word
						cnt_q <= ffra_pkg::CNT_W'(ev.lead);
						run_base_q <= word_base + PW'(W) - PW'(ev.lead);
					end
				end
			end
			ffra_pkg::ST_RANGE: begin
				hw_q <= WC_W'(hm1 >> OW);
				hoff_q <= hm1[OW-1:0];
			end
			ffra_pkg::ST_MARK: begin
				ev_q <= rd_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign ok = ok_q;
	assign base_index = base_q;

endmodule

`default_nettype wire

// ===== sim/first_fit_run_allocator_test.sv =====
// Self-checking testbench for first_fit_run_allocator: directed and random allocate/free traffic.
// A scoreboard class tracks slot occupancy and predicts each result; depends on ffra_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct {
	bit                        ok;
	bit [ffra_pkg::BASE_W-1:0] base;
} alloc_result_t;

class slot_map_scoreboard;
	bit            slot_used [ffra_pkg::SLOT_COUNT_DEF];
	alloc_result_t awaited_results [$];
	int unsigned   errors;

	function new();
		foreach (slot_used[i]) slot_used[i] = 1'b0;
		errors = 0;
	endfunction

	task report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		errors++;
	endtask

	// lowest base with len free slots; base jumps past each used slot it meets
	function bit first_fit_search(int unsigned len, output int unsigned base_found);
		int unsigned b;
		int unsigned run;
		b = 0;
		base_found = 0;
		if (len == 0 || len > ffra_pkg::SLOT_COUNT_DEF)
			return 1'b0;
		while (b + len <= ffra_pkg::SLOT_COUNT_DEF) begin
			run = 0;
			while (run < len && !slot_used[b + run])
				run++;
			if (run >= len) begin
				base_found = b;
				return 1'b1;
			end
			b = b + run + 1;
		end
		return 1'b0;
	endfunction

	function void note_command(logic c, logic [ffra_pkg::START_W-1:0] s,
		logic [ffra_pkg::LEN_W-1:0] l);
		int unsigned   last;
		int unsigned   b;
		alloc_result_t r;
		if (c == ffra_pkg::CMD_FREE) begin
			last = 32'(s) + 32'(l);
			if (last > ffra_pkg::SLOT_COUNT_DEF)
				last = ffra_pkg::SLOT_COUNT_DEF;
			for (int unsigned i = 32'(s); i < last; i++)
				slot_used[i] = 1'b0;
			r.ok = 1'b1;
			r.base = '0;
		end else if (first_fit_search(32'(l), b)) begin
			for (int unsigned i = 0; i < 32'(l); i++)
				slot_used[b + i] = 1'b1;
			r.ok = 1'b1;
			r.base = b[ffra_pkg::BASE_W-1:0];
		end else begin
			r.ok = 1'b0;
			r.base = '0;
		end
		awaited_results.push_back(r);
	endfunction

	task check_result(logic got_ok, logic [ffra_pkg::BASE_W-1:0] got_base);
		alloc_result_t r;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result ok=%b base=%0d", got_ok, got_base));
		end else begin
			r = awaited_results.pop_front();
			if (got_ok !== r.ok)
				report_mismatch($sformatf("ok got %b want %b", got_ok, r.ok));
			if (got_base !== r.base)
				report_mismatch($sformatf("base_index got %0d want %0d", got_base, r.base));
		end
	endtask

	task check_drained();
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
	endtask
endclass

module first_fit_run_allocator_test;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 200;
	localparam int unsigned RANDOM_ITEMS = 900;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          cmd;
	logic [ffra_pkg::START_W-1:0]  start_index;
	logic [ffra_pkg::LEN_W-1:0]    run_length;
	logic                          busy;
	logic                          done;
	logic                          ok;
	logic [ffra_pkg::BASE_W-1:0]   base_index;

	slot_map_scoreboard  tracker;
	int unsigned         cycle_count = 0;
	int unsigned         calm_left = 0;

	first_fit_run_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (cmd),
		.start_index (start_index),
		.run_length  (run_length),
		.busy        (busy),
		.done        (done),
		.ok          (ok),
		.base_index  (base_index)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(ok, base_index);
	end

	// holds start until the transfer, then tells the scoreboard
	task automatic send_command(logic c, logic [ffra_pkg::START_W-1:0] s,
		logic [ffra_pkg::LEN_W-1:0] l);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		start_index <= s;
		run_length <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		tracker.note_command(c, s, l);
	endtask

	task automatic idle_for(int unsigned n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			cmd <= 1'($urandom_range(0, 1));
			start_index <= ffra_pkg::START_W'($urandom_range(0, 2047));
			run_length <= ffra_pkg::LEN_W'($urandom_range(0, 4095));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left = $urandom_range(10, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_random_item();
		int unsigned r;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			// full clear keeps the map from staying saturated
			send_command(ffra_pkg::CMD_FREE, '0, ffra_pkg::LEN_W'(ffra_pkg::SLOT_COUNT_DEF));
		end else if (r < 57) begin
			r = $urandom_range(0, 99);
			if (r < 2) len = 0;
			else if (r < 70) len = $urandom_range(1, 40);
			else if (r < 92) len = $urandom_range(41, 256);
			else if (r < 98) len = $urandom_range(257, 1024);
			else len = $urandom_range(1025, 2048);
			send_command(ffra_pkg::CMD_ALLOC, ffra_pkg::START_W'($urandom_range(0, 2047)),
				len[ffra_pkg::LEN_W-1:0]);
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) len = 0;
			else if (r < 90) len = $urandom_range(1, 200);
			else len = $urandom_range(201, 2048);
			send_command(ffra_pkg::CMD_FREE, ffra_pkg::START_W'($urandom_range(0, 2047)),
				len[ffra_pkg::LEN_W-1:0]);
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = ffra_pkg::CMD_ALLOC;
		start_index = '0;
		run_length = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, clamped free, holes too small, word crossings
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd0);
		send_command(ffra_pkg::CMD_ALLOC, 11'd2047, 12'd2048);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd1);
		send_command(ffra_pkg::CMD_FREE, 11'd2047, 12'd2048);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd1);
		send_command(ffra_pkg::CMD_FREE, 11'd0, 12'd0);
		send_command(ffra_pkg::CMD_FREE, 11'd0, 12'd2048);
		send_command(ffra_pkg::CMD_FREE, 11'd100, 12'd50);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd1);
		send_command(ffra_pkg::CMD_ALLOC, 11'd5, 12'd31);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd33);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd2047);
		send_command(ffra_pkg::CMD_FREE, 11'd1, 12'd31);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd32);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd31);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd1951);
		send_command(ffra_pkg::CMD_FREE, 11'd1024, 12'd1);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd2);
		send_command(ffra_pkg::CMD_ALLOC, 11'd0, 12'd1);
		send_command(ffra_pkg::CMD_FREE, 11'd0, 12'd4095);
		send_command(ffra_pkg::CMD_ALLOC, 11'd2047, 12'd2048);
		send_command(ffra_pkg::CMD_FREE, 11'd0, 12'd2048);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			send_random_item();
			idle_for(pick_gap());
		end

		@(negedge clk);
		start <= 1'b0;
		while (tracker.awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		tracker.check_drained();
		if (tracker.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
